### hdl/ffpra_pkg.sv
// Package for the first-fit page region allocator.
// Holds transaction types, status and operation codes, and the cell interface types.
// No dependencies.
`default_nettype none
package ffpra_pkg;

   localparam int INDEX_BITS = 6;   // up to 64 regions
   localparam int COUNT_BITS = 7;   // region count, wide enough for 0..64
   localparam int PAGE_NUM_BITS = 16;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_ZERO        = 3'd1,
      ST_TOO_LARGE   = 3'd2,
      ST_NO_SPACE    = 3'd3,
      ST_TABLE_FULL  = 3'd4,
      ST_INVALID     = 3'd5,
      ST_DOUBLE_FREE = 3'd6
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SPLIT,
      OP_MARK_USED,
      OP_MARK_FREE,
      OP_MERGE
   } op_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_ALLOC_EDIT,
      FSM_FREE_MERGE1,
      FSM_FREE_MERGE2
   } fsm_type;

   typedef struct packed {
      logic        command;
      logic [31:0] request_bytes;
      logic [63:0] free_address;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] start_address;
   } rsp_type;

   // One table entry as seen by a neighbor.
   typedef struct packed {
      logic                     token;
      logic                     is_free;
      logic [PAGE_NUM_BITS-1:0] start_page;
      logic [PAGE_NUM_BITS-1:0] end_page;
   } cell_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic                     scan_en;
      logic                     free_cmd;
      logic [PAGE_NUM_BITS-1:0] key;
      logic [COUNT_BITS-1:0]    count;
      op_type                   op;
      logic [INDEX_BITS-1:0]    idx;
   } ctl_type;

endpackage
`default_nettype wire

### hdl/ffpra_cell.sv
// One region cell of the allocator chain: holds one table entry and the scan token.
// Depends on ffpra_pkg.
`default_nettype none
module ffpra_cell #(
   parameter int IDX         = 0,
   parameter int TOTAL_PAGES = 32768
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ffpra_pkg::ctl_type  ctl,
   input  wire ffpra_pkg::cell_type left_in,
   input  wire ffpra_pkg::cell_type right_in,
   output ffpra_pkg::cell_type      state_out,
   output logic                    hit
);
   import ffpra_pkg::*;

   localparam logic [COUNT_BITS-1:0] MY_IDX = COUNT_BITS'(IDX);

   logic                     token_ff, token_in;
   logic                     free_ff, free_in;
   logic [PAGE_NUM_BITS-1:0] start_ff, start_in;
   logic [PAGE_NUM_BITS-1:0] end_ff, end_in;
   logic [COUNT_BITS-1:0]    sel;
   logic [COUNT_BITS-1:0]    sel_next;
   logic [PAGE_NUM_BITS-1:0] len;
   logic                     active;

   always_comb begin
      sel      = {1'b0, ctl.idx};
      sel_next = sel + COUNT_BITS'(1);
      len      = end_ff - start_ff;
      active   = MY_IDX < ctl.count;
      token_in = ctl.scan_en & left_in.token;
      if (ctl.free_cmd) begin
         hit = token_ff & active & (start_ff == ctl.key);
      end else begin
         hit = token_ff & active & free_ff & (len >= ctl.key);
      end

      free_in  = free_ff;
      start_in = start_ff;
      end_in   = end_ff;
      unique case (ctl.op)
         OP_SPLIT: begin
            if (MY_IDX == sel) begin
               end_in  = start_ff + ctl.key;
               free_in = 1'b0;
            end else if (MY_IDX == sel_next) begin
               start_in = left_in.start_page + ctl.key;
               end_in   = left_in.end_page;
               free_in  = 1'b1;
            end else if (MY_IDX > sel_next) begin
               start_in = left_in.start_page;
               end_in   = left_in.end_page;
               free_in  = left_in.is_free;
            end
         end
         OP_MARK_USED: begin
            if (MY_IDX == sel) free_in = 1'b0;
         end
         OP_MARK_FREE: begin
            if (MY_IDX == sel) free_in = 1'b1;
         end
         OP_MERGE: begin
            // Absorb the right neighbor; everything above slides down one place.
            if (MY_IDX == sel) begin
               end_in  = right_in.end_page;
               free_in = 1'b1;
            end else if (MY_IDX > sel) begin
               start_in = right_in.start_page;
               end_in   = right_in.end_page;
               free_in  = right_in.is_free;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
         free_ff  <= 1'b1;
         start_ff <= '0;
         end_ff   <= PAGE_NUM_BITS'(TOTAL_PAGES);
      end else begin
         token_ff <= token_in;
         free_ff  <= free_in;
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   assign state_out = '{token: token_ff, is_free: free_ff,
                        start_page: start_ff, end_page: end_ff};

endmodule
`default_nettype wire

### hdl/first_fit_page_region_allocator_unit.sv
// First-fit page region allocator: a chain of region cells plus a small sequencer.
// Rejected sizes or addresses are answered from idle; else a token scans up to
// MAX_REGIONS cells, one per cycle, then the edit state runs for an allocation or
// the merge states for a free. A scan that finds nothing or a double free ends there.
// Throughput: one transaction at a time; a new one is taken the cycle its result shows.
// Reset (synchronous, active high): one free region covers the window, base is zero.
`default_nettype none
module first_fit_page_region_allocator_unit #(
   parameter int PAGE_BYTES  = 4096,
   parameter int TOTAL_PAGES = 32768,
   parameter int MAX_REGIONS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ffpra_pkg::req_type req_data,
   output logic                   rsp_valid,
   output ffpra_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [63:0]       csr_wr_data
);
   import ffpra_pkg::*;

   localparam int PAGE_BITS = $clog2(PAGE_BYTES);
   localparam logic [32:0] MAX_BYTES = 33'(longint'(TOTAL_PAGES) * longint'(PAGE_BYTES));
   localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_REGIONS);

   // Sequencer state.
   fsm_type                  state_ff, state_in;
   logic [63:0]              base_ff;
   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0]    scan_ff, scan_in;
   logic                     cmd_ff, cmd_in;
   logic [PAGE_NUM_BITS-1:0] key_ff, key_in;
   logic [INDEX_BITS-1:0]    idx_ff, idx_in;
   logic [PAGE_NUM_BITS-1:0] hstart_ff, hstart_in;
   logic [PAGE_NUM_BITS-1:0] hend_ff, hend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   // Chain signals.
   ctl_type                  ctl;
   logic                     launch;
   cell_type                 cell_q [MAX_REGIONS];
   logic [MAX_REGIONS-1:0]   hit_vec;
   logic [MAX_REGIONS-1:0]   free_vec;
   cell_type                 hit_data;

   // Request decode.
   logic [32:0]              pages_wide;
   logic [63:0]              diff;
   logic                     target_ok;
   logic [PAGE_NUM_BITS-1:0] hit_len;
   logic [COUNT_BITS-1:0]    idx_ext;

   genvar g;
   generate
      for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
         cell_type left_c, right_c;
         if (g == 0) begin : g_first
            assign left_c = '{token: launch, is_free: 1'b0, start_page: '0, end_page: '0};
         end else begin : g_mid
            assign left_c = cell_q[g-1];
         end
         if (g == MAX_REGIONS - 1) begin : g_last
            assign right_c = '0;
         end else begin : g_inner
            assign right_c = cell_q[g+1];
         end
         ffpra_cell #(.IDX(g), .TOTAL_PAGES(TOTAL_PAGES)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .left_in   (left_c),
            .right_in  (right_c),
            .state_out (cell_q[g]),
            .hit       (hit_vec[g])
         );
         assign free_vec[g] = cell_q[g].is_free;
      end
   endgenerate

   // The token sits in at most one cell, so at most one hit: an AND-OR select suffices.
   always_comb begin
      hit_data = '0;
      for (int k = 0; k < MAX_REGIONS; k++) begin
         hit_data = hit_data | (hit_vec[k] ? cell_q[k] : '0);
      end
   end

   always_comb begin
      pages_wide = ({1'b0, req_data.request_bytes} + 33'(PAGE_BYTES - 1)) >> PAGE_BITS;
      diff       = req_data.free_address - base_ff;
      target_ok  = (diff[PAGE_BITS-1:0] == '0) && (diff[63:PAGE_BITS+PAGE_NUM_BITS] == '0);
      hit_len    = hend_ff - hstart_ff;
      idx_ext    = {1'b0, idx_ff};
   end

   // Next-state and output logic of the sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      hstart_in    = hstart_ff;
      hend_in      = hend_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '{status: ST_OK, start_address: '0};
      launch       = 1'b0;
      ctl          = '{scan_en: 1'b0, free_cmd: cmd_ff, key: key_ff, count: cnt_ff,
                       op: OP_NONE, idx: idx_ff};

      unique case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               cmd_in = req_data.command;
               if (req_data.command == CMD_ALLOC) begin
                  if (req_data.request_bytes == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_ZERO;
                  end else if ({1'b0, req_data.request_bytes} > MAX_BYTES) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_TOO_LARGE;
                  end else begin
                     key_in   = pages_wide[PAGE_NUM_BITS-1:0];
                     launch   = 1'b1;
                     scan_in  = '0;
                     state_in = FSM_SCAN;
                  end
               end else begin
                  if (target_ok) begin
                     key_in   = diff[PAGE_BITS +: PAGE_NUM_BITS];
                     launch   = 1'b1;
                     scan_in  = '0;
                     state_in = FSM_SCAN;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_INVALID;
                  end
               end
               ctl.scan_en = launch;
            end
         end
         FSM_SCAN: begin
            ctl.scan_en = 1'b1;
            if (|hit_vec) begin
               ctl.scan_en = 1'b0;
               idx_in    = scan_ff[INDEX_BITS-1:0];
               hstart_in = hit_data.start_page;
               hend_in   = hit_data.end_page;
               if (cmd_ff == CMD_ALLOC) begin
                  state_in = FSM_ALLOC_EDIT;
               end else if (hit_data.is_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_DOUBLE_FREE;
                  state_in      = FSM_IDLE;
               end else begin
                  state_in = FSM_FREE_MERGE1;
               end
            end else if (scan_ff + COUNT_BITS'(1) >= cnt_ff) begin
               ctl.scan_en   = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_in.status = (cmd_ff == CMD_ALLOC) ? ST_NO_SPACE : ST_INVALID;
               state_in      = FSM_IDLE;
            end else begin
               scan_in = scan_ff + COUNT_BITS'(1);
            end
         end
         FSM_ALLOC_EDIT: begin
            rsp_valid_in = 1'b1;
            state_in     = FSM_IDLE;
            if (hit_len != key_ff && cnt_ff == MAX_COUNT) begin
               rsp_in.status = ST_TABLE_FULL;
            end else begin
               if (hit_len != key_ff) begin
                  ctl.op = OP_SPLIT;
                  cnt_in = cnt_ff + COUNT_BITS'(1);
               end else begin
                  ctl.op = OP_MARK_USED;
               end
               rsp_in.status        = ST_OK;
               rsp_in.start_address = base_ff + ({48'b0, hstart_ff} << PAGE_BITS);
            end
         end
         FSM_FREE_MERGE1: begin
            // Fold into a free left neighbor, else just mark the region free.
            state_in = FSM_FREE_MERGE2;
            if (idx_ff != '0 && free_vec[idx_ff - INDEX_BITS'(1)]) begin
               ctl.op  = OP_MERGE;
               ctl.idx = idx_ff - INDEX_BITS'(1);
               idx_in  = idx_ff - INDEX_BITS'(1);
               cnt_in  = cnt_ff - COUNT_BITS'(1);
            end else begin
               ctl.op = OP_MARK_FREE;
            end
         end
         FSM_FREE_MERGE2: begin
            // Then absorb a free right neighbor, if there is one.
            if (idx_ext + COUNT_BITS'(1) < cnt_ff && free_vec[idx_ff + INDEX_BITS'(1)]) begin
               ctl.op = OP_MERGE;
               cnt_in = cnt_ff - COUNT_BITS'(1);
            end
            rsp_valid_in  = 1'b1;
            rsp_in.status = ST_OK;
            state_in      = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         base_ff      <= '0;
         cnt_ff       <= COUNT_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      hstart_ff <= hstart_in;
      hend_ff   <= hend_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // The region count always stays within the table.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff >= COUNT_BITS'(1)) && (cnt_ff <= MAX_COUNT))
      else $error("region count out of range");

   // Only the token cell can report a hit.
   a_one_hit: assert property (@(posedge clock) disable iff (reset) $onehot0(hit_vec))
      else $error("more than one cell hit");

   // A result is shown only when the sequencer has returned to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result while busy");

   // A failed transaction never reports an address.
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.start_address == '0))
      else $error("address on failed transaction");
`endif

endmodule
`default_nettype wire
